### hw/rtl/lbbp_pkg.sv
// ----------------------------------------------------------------------------
// lbbp_pkg
// shared types, register codes and constants for the led pattern block
// ----------------------------------------------------------------------------
package lbbp_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PER_W   = 16;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned PROD_W  = CHAN_W + PCT_W;
  localparam int unsigned NUM_W   = 23;
  localparam int unsigned NCHAN   = 6;

  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_FLOOR = 7'd10;

  // x / 100 as (x * 5243) >> 19, exact for x below 25600
  localparam int unsigned RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  // divider retires this many quotient bits per step
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned CNT_W     = 3;
  localparam logic [CNT_W-1:0] MOD_LAST = 3'(TIME_W / DIV_BITS - 1);
  localparam logic [CNT_W-1:0] PCT_LAST = 3'(CHAN_W / DIV_BITS - 1);

  typedef enum logic [2:0] {
    REG_ENABLE = 3'd0,
    REG_MODE   = 3'd1,
    REG_PERIOD = 3'd2,
    REG_DEV    = 3'd3,
    REG_FRONT  = 3'd4,
    REG_MIRROR = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_SOLID   = 2'd0,
    MODE_BLINK   = 2'd1,
    MODE_BREATHE = 2'd2,
    MODE_OFF     = 2'd3
  } mode_t;

  typedef struct packed {
    logic accept;
    logic div_load_mod;
    logic div_load_pct;
    logic div_step;
    logic set_pct;
    logic scale;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic enable;
    logic breathe;
    logic half_zero;
  } dp_sts_t;

  function automatic logic [CHAN_W-1:0] div100(input logic [PROD_W-1:0] x);
    logic [PROD_W+RECIP_W-1:0] p;
    p = (PROD_W+RECIP_W)'(x) * (PROD_W+RECIP_W)'(RECIP);
    return p[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
  endfunction

endpackage

### hw/rtl/lbbp_div.sv
// ----------------------------------------------------------------------------
// lbbp_div
// iterative restoring divider, several quotient bits per step
// ----------------------------------------------------------------------------
module lbbp_div import lbbp_pkg::*; (
  input  logic              clk,
  input  logic              load,
  input  logic              step,
  input  logic [PER_W-1:0]  rem_init,
  input  logic [TIME_W-1:0] dvd_init,
  input  logic [PER_W-1:0]  dvs_init,
  output logic [PER_W-1:0]  rem,
  output logic [CHAN_W-1:0] quo
);

  logic [PER_W-1:0]  rem_r, rem_nxt;
  logic [TIME_W-1:0] sh_r, sh_nxt;
  logic [PER_W-1:0]  dvs_r;

  always_comb begin
    logic [PER_W:0] t;
    logic           q;
    rem_nxt = rem_r;
    sh_nxt  = sh_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {rem_nxt, sh_nxt[TIME_W-1]};
      q = (t >= {1'b0, dvs_r});
      if (q) begin
        rem_nxt = PER_W'(t - {1'b0, dvs_r});
      end else begin
        rem_nxt = t[PER_W-1:0];
      end
      sh_nxt = {sh_nxt[TIME_W-2:0], q};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= rem_init;
      sh_r  <= dvd_init;
      dvs_r <= dvs_init;
    end else if (step) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
    end
  end

  assign rem = rem_r;
  assign quo = sh_r[CHAN_W-1:0];

endmodule

### hw/rtl/lbbp_dp.sv
// ----------------------------------------------------------------------------
// lbbp_dp
// datapath: config registers, blink state, breathe percent, channel scaling
// ----------------------------------------------------------------------------
module lbbp_dp import lbbp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [COLOR_W-1:0] cfg_data,
  input  logic [TIME_W-1:0]  in_now_ms,
  input  logic               in_restart,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  output logic [CHAN_W-1:0]  out_dev_red,
  output logic [CHAN_W-1:0]  out_dev_green,
  output logic [CHAN_W-1:0]  out_dev_blue,
  output logic [CHAN_W-1:0]  out_front_red,
  output logic [CHAN_W-1:0]  out_front_green,
  output logic [CHAN_W-1:0]  out_front_blue
);

  logic               enable_r;
  mode_t              mode_r;
  logic [PER_W-1:0]   period_r;
  logic [COLOR_W-1:0] dev_color_r;
  logic [COLOR_W-1:0] front_color_r;
  logic               mirror_r;

  logic [TIME_W-1:0]  last_r, last_nxt;
  logic               blink_r, blink_nxt;

  logic [COLOR_W-1:0] dev_src_r, front_src_r;
  logic [PCT_W-1:0]   pct_r;
  logic [PROD_W-1:0]  prod_r [NCHAN];
  logic [CHAN_W-1:0]  out_r  [NCHAN];

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      mode_r        <= MODE_SOLID;
      period_r      <= 16'd1000;
      dev_color_r   <= '0;
      front_color_r <= '0;
      mirror_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_ENABLE: enable_r      <= cfg_data[0];
        REG_MODE:   mode_r        <= mode_t'(cfg_data[1:0]);
        REG_PERIOD: period_r      <= cfg_data[PER_W-1:0];
        REG_DEV:    dev_color_r   <= cfg_data;
        REG_FRONT:  front_color_r <= cfg_data;
        REG_MIRROR: mirror_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // blink state, restart clears before the tick is evaluated
  logic [TIME_W-1:0]  last_eff;
  logic               on_eff, toggle, on_new, show;
  logic [PER_W-2:0]   half;

  assign last_eff = in_restart ? '0 : last_r;
  assign on_eff   = in_restart ? 1'b0 : blink_r;
  assign toggle   = (mode_r == MODE_BLINK) &&
                    (TIME_W'(in_now_ms - last_eff) >= TIME_W'(period_r));
  assign on_new   = on_eff ^ toggle;
  assign show     = (mode_r == MODE_SOLID) || (mode_r == MODE_BREATHE) ||
                    ((mode_r == MODE_BLINK) && on_new);
  assign half     = period_r[PER_W-1:1];

  always_comb begin
    last_nxt  = last_r;
    blink_nxt = blink_r;
    if (cmd.accept) begin
      last_nxt  = last_eff;
      blink_nxt = on_eff;
      if (enable_r && toggle) begin
        last_nxt  = in_now_ms;
        blink_nxt = ~on_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      blink_r <= 1'b0;
    end else begin
      last_r  <= last_nxt;
      blink_r <= blink_nxt;
    end
  end

  assign sts.enable    = enable_r;
  assign sts.breathe   = (mode_r == MODE_BREATHE);
  assign sts.half_zero = (half == '0);

  // divider operands: phase = now mod period, then percent = num / half
  logic [PER_W-1:0]  div_rem;
  logic [CHAN_W-1:0] div_quo;
  logic [PER_W-1:0]  tri_op;
  logic [NUM_W-1:0]  num;
  logic [PER_W-1:0]  rem_init, dvs_init;
  logic [TIME_W-1:0] dvd_init;

  assign tri_op = (div_rem < {1'b0, half}) ? div_rem : PER_W'(period_r - div_rem);
  assign num    = NUM_W'(tri_op) * NUM_W'(PCT_FULL);

  always_comb begin
    if (cmd.div_load_pct) begin
      rem_init = {1'b0, num[NUM_W-1:CHAN_W]};
      dvd_init = {num[CHAN_W-1:0], {(TIME_W-CHAN_W){1'b0}}};
      dvs_init = {1'b0, half};
    end else begin
      rem_init = '0;
      dvd_init = in_now_ms;
      dvs_init = period_r;
    end
  end

  lbbp_div u_div (
    .clk      (clk),
    .load     (cmd.div_load_mod | cmd.div_load_pct),
    .step     (cmd.div_step),
    .rem_init (rem_init),
    .dvd_init (dvd_init),
    .dvs_init (dvs_init),
    .rem      (div_rem),
    .quo      (div_quo)
  );

  // clamp to 10..100, odd periods overshoot on the falling half
  logic [PCT_W-1:0] pct_clamp;
  always_comb begin
    if (div_quo > CHAN_W'(PCT_FULL)) begin
      pct_clamp = PCT_FULL;
    end else if (div_quo < CHAN_W'(PCT_FLOOR)) begin
      pct_clamp = PCT_FLOOR;
    end else begin
      pct_clamp = div_quo[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dev_src_r   <= show ? dev_color_r : '0;
      front_src_r <= show ? (mirror_r ? dev_color_r : front_color_r) : '0;
      pct_r       <= PCT_FULL;
    end else if (cmd.set_pct) begin
      pct_r <= pct_clamp;
    end
  end

  // channel scaling: multiply, then divide by 100 through the reciprocal
  logic [CHAN_W-1:0] chan [NCHAN];
  assign chan[0] = dev_src_r[23:16];
  assign chan[1] = dev_src_r[15:8];
  assign chan[2] = dev_src_r[7:0];
  assign chan[3] = front_src_r[23:16];
  assign chan[4] = front_src_r[15:8];
  assign chan[5] = front_src_r[7:0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < NCHAN; i++) begin
      if (cmd.scale) begin
        prod_r[i] <= PROD_W'(chan[i]) * PROD_W'(pct_r);
      end
      if (cmd.load_out) begin
        out_r[i] <= div100(prod_r[i]);
      end
    end
  end

  assign out_dev_red     = out_r[0];
  assign out_dev_green   = out_r[1];
  assign out_dev_blue    = out_r[2];
  assign out_front_red   = out_r[3];
  assign out_front_green = out_r[4];
  assign out_front_blue  = out_r[5];

endmodule

### hw/rtl/lbbp_ctrl.sv
// ----------------------------------------------------------------------------
// lbbp_ctrl
// controller: sequences one word through the datapath, owns the handshakes
// ----------------------------------------------------------------------------
module lbbp_ctrl import lbbp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MOD    = 7'b0000010,
    S_NUM    = 7'b0000100,
    S_PCT    = 7'b0001000,
    S_SETPCT = 7'b0010000,
    S_SCALE  = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.enable) begin
            if (sts.breathe && !sts.half_zero) begin
              cmd.div_load_mod = 1'b1;
              cnt_nxt          = '0;
              state_nxt        = S_MOD;
            end else begin
              state_nxt = S_SCALE;
            end
          end
        end
      end
      S_MOD: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = CNT_W'(cnt_r + 1'b1);
        if (cnt_r == MOD_LAST) begin
          state_nxt = S_NUM;
        end
      end
      S_NUM: begin
        cmd.div_load_pct = 1'b1;
        cnt_nxt          = '0;
        state_nxt        = S_PCT;
      end
      S_PCT: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = CNT_W'(cnt_r + 1'b1);
        if (cnt_r == PCT_LAST) begin
          state_nxt = S_SETPCT;
        end
      end
      S_SETPCT: begin
        cmd.set_pct = 1'b1;
        state_nxt   = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hw/rtl/led_blink_breathe_pattern.sv
// ----------------------------------------------------------------------------
// led_blink_breathe_pattern
// two rgb leds driven solid, blinking, breathing or off from millisecond ticks
// ----------------------------------------------------------------------------
//
//   channel   direction  word
//   in_       input      now_ms (32), restart (1)
//   out_      output     dev rgb and front rgb, 8 bits per color
//   cfg_      input      register index (3), data (24); always ready
//
// a word taken while disabled gives no result; solid, blink and off words
//   pass through accept, scale and emit; unless the period is below two,
//   breathe words first run the shared divider, which retires 4 quotient
//   bits a step: 8 steps for now mod period, 2 for the percent
// one word in flight at a time; the next word is taken while a result sits
//   in the output register, and the emit step waits only if it is still full
// rst_n is synchronous; it clears the control state, the blink state and
//   loads the register defaults (period 1000, everything else zero)
//
module led_blink_breathe_pattern import lbbp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // tick input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TIME_W-1:0]  in_now_ms,
  input  logic               in_restart,
  // led colors
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAN_W-1:0]  out_dev_red,
  output logic [CHAN_W-1:0]  out_dev_green,
  output logic [CHAN_W-1:0]  out_dev_blue,
  output logic [CHAN_W-1:0]  out_front_red,
  output logic [CHAN_W-1:0]  out_front_green,
  output logic [CHAN_W-1:0]  out_front_blue,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [COLOR_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // writes go straight into the registers, so the port never stalls
  assign cfg_ready = 1'b1;

  // sequencing: accept, divide steps for breathe, scale, emit
  lbbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // registers, blink state, divider and the output word
  lbbp_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_now_ms       (in_now_ms),
    .in_restart      (in_restart),
    .cmd             (cmd),
    .sts             (sts),
    .out_dev_red     (out_dev_red),
    .out_dev_green   (out_dev_green),
    .out_dev_blue    (out_dev_blue),
    .out_front_red   (out_front_red),
    .out_front_green (out_front_green),
    .out_front_blue  (out_front_blue)
  );

endmodule

### hw/rtl/lbbp_chk.sv
// ----------------------------------------------------------------------------
// lbbp_chk
// port-level checks for the led pattern block, bound to the top level
// ----------------------------------------------------------------------------
module lbbp_chk import lbbp_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [CHAN_W-1:0]  out_dev_red,
  input logic [CHAN_W-1:0]  out_dev_green,
  input logic [CHAN_W-1:0]  out_dev_blue,
  input logic [CHAN_W-1:0]  out_front_red,
  input logic [CHAN_W-1:0]  out_front_green,
  input logic [CHAN_W-1:0]  out_front_blue,
  input logic               cfg_ready
);

  // register writes never stall
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("cfg_ready dropped");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // a result needs at least a scale step after its word is taken
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result one cycle after accept");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dev_red) &&
      $stable(out_dev_green) && $stable(out_dev_blue) &&
      $stable(out_front_red) && $stable(out_front_green) &&
      $stable(out_front_blue))
    else $error("stalled result changed");

endmodule

bind led_blink_breathe_pattern lbbp_chk u_lbbp_chk (.*);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the led pattern block: drives millisecond ticks and
// register writes, predicts each led word and compares it with the block
// ----------------------------------------------------------------------------
module testbench;
  import lbbp_pkg::*;

  // register indexes past the end of the list, writes to them are dropped
  localparam logic [2:0] IDX_SPARE0 = 3'(REG_MIRROR) + 3'd1;
  localparam logic [2:0] IDX_SPARE1 = IDX_SPARE0 + 3'd1;
  localparam int unsigned SETTLE_CYC = 40;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              restart;
  } tick_t;

  typedef struct packed {
    logic [CHAN_W-1:0] dev_red;
    logic [CHAN_W-1:0] dev_green;
    logic [CHAN_W-1:0] dev_blue;
    logic [CHAN_W-1:0] front_red;
    logic [CHAN_W-1:0] front_green;
    logic [CHAN_W-1:0] front_blue;
  } led_frame_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [TIME_W-1:0]  in_now_ms = '0;
  logic               in_restart = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CHAN_W-1:0]  out_dev_red;
  logic [CHAN_W-1:0]  out_dev_green;
  logic [CHAN_W-1:0]  out_dev_blue;
  logic [CHAN_W-1:0]  out_front_red;
  logic [CHAN_W-1:0]  out_front_green;
  logic [CHAN_W-1:0]  out_front_blue;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [COLOR_W-1:0] cfg_data = '0;

  // mirror of the block registers, defaults after reset
  logic               cur_enable = 1'b0;
  mode_t              cur_mode = MODE_SOLID;
  logic [PER_W-1:0]   cur_period = 16'd1000;
  logic [COLOR_W-1:0] cur_dev = '0;
  logic [COLOR_W-1:0] cur_front = '0;
  logic               cur_mirror = 1'b0;

  // blink state
  logic [TIME_W-1:0]  toggle_ms = '0;
  logic               blink_lit = 1'b0;

  tick_t      ticks_pending[$];
  led_frame_t led_frames_due[$];
  int unsigned ticks_queued = 0;
  int unsigned ticks_taken = 0;
  int unsigned err_cnt = 0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  logic        in_calm = 1'b0;
  logic        out_calm = 1'b0;

  led_blink_breathe_pattern uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_now_ms      (in_now_ms),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dev_red    (out_dev_red),
    .out_dev_green  (out_dev_green),
    .out_dev_blue   (out_dev_blue),
    .out_front_red  (out_front_red),
    .out_front_green(out_front_green),
    .out_front_blue (out_front_blue),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  // idle length: mostly short, now and then long, none in calm stretches
  function automatic int unsigned pick_gap(logic calm);
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // one color channel times percent, truncated
  function automatic logic [CHAN_W-1:0] scale_chan(logic [CHAN_W-1:0] c, int unsigned pct);
    return CHAN_W'((c * pct) / 100);
  endfunction

  // advance the blink state for one tick and queue the led word it gives
  function automatic void predict_leds(logic [TIME_W-1:0] now, logic restart);
    led_frame_t         f;
    int unsigned        pct;
    int unsigned        half;
    int unsigned        phase;
    logic [TIME_W-1:0]  elapsed;
    logic [COLOR_W-1:0] dev_c;
    logic [COLOR_W-1:0] front_c;
    // restart clears blink state even while disabled
    if (restart) begin
      toggle_ms = '0;
      blink_lit = 1'b0;
    end
    if (!cur_enable) return;
    pct = 32'(PCT_FULL);
    dev_c = cur_dev;
    front_c = cur_front;
    case (cur_mode)
      MODE_SOLID: begin
      end
      MODE_BLINK: begin
        // elapsed time wraps with the 32-bit clock
        elapsed = now - toggle_ms;
        if (elapsed >= TIME_W'(cur_period)) begin
          toggle_ms = now;
          blink_lit = ~blink_lit;
        end
        if (!blink_lit) begin
          dev_c = '0;
          front_c = '0;
        end
      end
      MODE_BREATHE: begin
        half = cur_period / 2;
        // periods below two leave the colors at full value
        if (half != 0) begin
          phase = now % TIME_W'(cur_period);
          if (phase < half) pct = (phase * 100) / half;
          else pct = ((cur_period - phase) * 100) / half;
          // odd periods can overshoot on the falling half
          if (pct > PCT_FULL) pct = 32'(PCT_FULL);
          if (pct < PCT_FLOOR) pct = 32'(PCT_FLOOR);
        end
      end
      default: begin
        dev_c = '0;
        front_c = '0;
      end
    endcase
    if (cur_mirror) front_c = dev_c;
    f.dev_red     = scale_chan(dev_c[23:16], pct);
    f.dev_green   = scale_chan(dev_c[15:8], pct);
    f.dev_blue    = scale_chan(dev_c[7:0], pct);
    f.front_red   = scale_chan(front_c[23:16], pct);
    f.front_green = scale_chan(front_c[15:8], pct);
    f.front_blue  = scale_chan(front_c[7:0], pct);
    led_frames_due.push_back(f);
  endfunction

  function automatic void check_chan(string name, logic [CHAN_W-1:0] want,
                                     logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // tick driver: valid stays up with a steady word until it is taken
  always @(posedge clk) begin : tick_drive
    tick_t t;
    logic  busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        // registers only change while idle, so the current copy holds
        predict_leds(in_now_ms, in_restart);
        ticks_taken++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (ticks_pending.size() != 0) begin
          t = ticks_pending.pop_front();
          in_now_ms <= t.now_ms;
          in_restart <= t.restart;
          in_valid <= 1'b1;
          in_gap <= pick_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // led word monitor with random back-pressure
  always @(posedge clk) begin : led_watch
    led_frame_t want;
    logic       taken;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold <= 0;
    end else begin
      taken = out_valid && out_ready;
      if (taken) begin
        if (led_frames_due.size() == 0) begin
          $error("led word with nothing expected");
          err_cnt++;
        end else begin
          want = led_frames_due.pop_front();
          check_chan("dev_red", want.dev_red, out_dev_red);
          check_chan("dev_green", want.dev_green, out_dev_green);
          check_chan("dev_blue", want.dev_blue, out_dev_blue);
          check_chan("front_red", want.front_red, out_front_red);
          check_chan("front_green", want.front_green, out_front_green);
          check_chan("front_blue", want.front_blue, out_front_blue);
        end
      end
      if (out_hold != 0) begin
        out_hold <= out_hold - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        // stall after a word, and now and then while waiting for one
        if (taken || $urandom_range(15) == 0) out_hold <= pick_gap(out_calm);
      end
    end
  end

  // one register write, the local copy follows at the handshake
  task automatic write_reg(logic [2:0] idx, logic [COLOR_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ENABLE: cur_enable = data[0];
      REG_MODE:   cur_mode = mode_t'(data[1:0]);
      REG_PERIOD: cur_period = data[PER_W-1:0];
      REG_DEV:    cur_dev = data;
      REG_FRONT:  cur_front = data;
      REG_MIRROR: cur_mirror = data[0];
      default: begin
      end
    endcase
  endtask

  // full register set; narrow registers get junk in the unused upper bits
  task automatic set_regs(logic en, mode_t mode, logic [PER_W-1:0] per,
                          logic [COLOR_W-1:0] dev_c, logic [COLOR_W-1:0] front_c,
                          logic mir);
    write_reg(REG_MODE, (COLOR_W'($urandom) & ~24'h3) | COLOR_W'(mode));
    write_reg(REG_PERIOD, (COLOR_W'($urandom) & ~24'hffff) | COLOR_W'(per));
    write_reg(REG_DEV, dev_c);
    write_reg(REG_FRONT, front_c);
    write_reg(REG_MIRROR, (COLOR_W'($urandom) & ~24'h1) | COLOR_W'(mir));
    if ($urandom_range(5) == 0) write_reg($urandom_range(1) ? IDX_SPARE1 : IDX_SPARE0,
                                          COLOR_W'($urandom));
    write_reg(REG_ENABLE, (COLOR_W'($urandom) & ~24'h1) | COLOR_W'(en));
  endtask

  task automatic queue_tick(logic [TIME_W-1:0] now, logic restart);
    tick_t t;
    t.now_ms = now;
    t.restart = restart;
    ticks_pending.push_back(t);
    ticks_queued++;
  endtask

  // wait until every tick is taken and every word is back, then let the
  // block finish any tick that gives no word
  task automatic drain();
    do @(negedge clk); while (ticks_taken != ticks_queued || led_frames_due.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  function automatic logic [COLOR_W-1:0] pick_color();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return COLOR_W'($urandom);
  endfunction

  function automatic logic [PER_W-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'd1;
    if (r == 2) return 16'd2;
    if (r == 3) return 16'hffff;
    if (r == 4) return 16'hfffe;
    if (r < 13) return PER_W'($urandom_range(40, 3));
    if (r < 17) return PER_W'($urandom_range(1000, 41));
    return PER_W'($urandom_range(65533, 1001));
  endfunction

  initial begin : stimulus
    logic [TIME_W-1:0] t;
    int unsigned       n;
    int unsigned       r;
    int unsigned       span;
    logic [PER_W-1:0]  per;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // disabled after reset: no words, restart still lands in the state
    queue_tick('0, 1'b1);
    queue_tick('1, 1'b0);
    drain();

    // solid at the color extremes, time at both ends
    set_regs(1'b1, MODE_SOLID, 16'd1000, '1, '0, 1'b0);
    queue_tick('0, 1'b0);
    queue_tick('1, 1'b1);
    drain();

    // off pattern is all black
    set_regs(1'b1, MODE_OFF, 16'd1000, 24'h123456, 24'habcdef, 1'b1);
    queue_tick(32'd77, 1'b0);
    drain();

    // front mirrors dev
    set_regs(1'b1, MODE_SOLID, 16'd1000, 24'h80ff01, 24'h5a5a5a, 1'b1);
    queue_tick(32'd5, 1'b0);
    drain();

    // blink with period zero flips on every tick
    set_regs(1'b1, MODE_BLINK, 16'd0, 24'hffffff, 24'h010203, 1'b0);
    repeat (3) queue_tick(32'd9, 1'b0);
    drain();

    // blink with a short period, restart in the middle
    set_regs(1'b1, MODE_BLINK, 16'd5, 24'h112233, 24'hfedcba, 1'b0);
    queue_tick(32'd3, 1'b1);
    queue_tick(32'd5, 1'b0);
    queue_tick(32'd7, 1'b0);
    queue_tick(32'd10, 1'b0);
    queue_tick(32'd11, 1'b1);
    queue_tick(32'd12, 1'b0);
    drain();

    // breathe with periods below two shows full color
    set_regs(1'b1, MODE_BREATHE, 16'd1, 24'hc8c8c8, 24'h0a0b0c, 1'b0);
    queue_tick(32'd123, 1'b0);
    drain();
    set_regs(1'b1, MODE_BREATHE, 16'd0, 24'hff8001, 24'hffffff, 1'b0);
    queue_tick('1, 1'b0);
    drain();

    // odd period: falling half overshoots and gets clamped, floor at phase zero
    set_regs(1'b1, MODE_BREATHE, 16'd7, 24'hffffff, 24'h646464, 1'b0);
    queue_tick(32'd3, 1'b0);
    queue_tick(32'd4, 1'b0);
    queue_tick(32'd6, 1'b0);
    queue_tick(32'd7, 1'b0);
    drain();

    // longest period against the top of the clock
    set_regs(1'b1, MODE_BREATHE, 16'hffff, 24'hffffff, 24'hffffff, 1'b1);
    queue_tick('1, 1'b0);
    queue_tick(32'd32767, 1'b0);
    drain();

    // restart while disabled must still reach the blink state
    set_regs(1'b1, MODE_BLINK, 16'd100, 24'h445566, 24'h778899, 1'b0);
    queue_tick(32'd200, 1'b0);
    drain();
    set_regs(1'b0, MODE_BLINK, 16'd100, 24'h445566, 24'h778899, 1'b0);
    queue_tick(32'd210, 1'b1);
    drain();
    set_regs(1'b1, MODE_BLINK, 16'd100, 24'h445566, 24'h778899, 1'b0);
    queue_tick(32'd150, 1'b0);
    drain();

    // random phases: new settings, then a run of ticks with random content
    t = '0;
    while (ticks_queued < 1300) begin
      per = pick_period();
      set_regs($urandom_range(9) != 0, mode_t'($urandom_range(3)), per,
               pick_color(), pick_color(), 1'($urandom_range(1)));
      in_calm = ($urandom_range(3) == 0);
      out_calm = ($urandom_range(3) == 0);
      span = (per == 0) ? 1 : 32'(per);
      // starting time: anywhere, near the wrap, near zero or carried over
      r = $urandom_range(9);
      if (r < 4) t = $urandom;
      else if (r < 6) t = '1 - TIME_W'($urandom_range(3 * span + 100));
      else if (r < 8) t = TIME_W'($urandom_range(1000));
      n = $urandom_range(40, 8);
      repeat (n) begin
        r = $urandom_range(99);
        // mostly ticks that move forward a little, as a real clock does
        if (r < 70) t = t + TIME_W'($urandom_range(span / 2 + 1));
        else if (r < 85) t = t + TIME_W'($urandom_range(2 * span + 1, span));
        else if (r < 95) t = t + TIME_W'($urandom_range(3));
        else t = $urandom;
        queue_tick(t, $urandom_range(15) == 0);
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    #12_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

### sim.f
hw/rtl/lbbp_pkg.sv
hw/rtl/lbbp_div.sv
hw/rtl/lbbp_dp.sv
hw/rtl/lbbp_ctrl.sv
hw/rtl/led_blink_breathe_pattern.sv
hw/rtl/lbbp_chk.sv
tb/testbench.sv
